// File: rtl/e2c_pkg.sv
// shared types, constants and helpers for the epoch seconds to calendar block
package e2c_pkg;

    // calendar constants
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned LEAP_SKIP     = 2100;  // only non-leap multiple of four in range

    // widths of the datapath
    localparam int unsigned SECS_W  = 32;
    localparam int unsigned QUO_W   = 16;  // whole days stay below 2^16
    localparam int unsigned YEAR_W  = 12;  // years 1970 to 2106
    localparam int unsigned STEP_W  = 4;

    // reciprocals for the constant divisions, after the power-of-two part is shifted off
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675), count >> 7
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225), seconds >> 4
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15), seconds >> 2

    // last month index, december
    localparam logic [3:0] LAST_MON = 4'd11;

    // datapath operations
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_QUO,
        OP_TAKE_DAYS,
        OP_TAKE_HOUR,
        OP_TAKE_MIN,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    // divisor select for the quotient and remainder steps
    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_HOUR,
        DSEL_MIN
    } t_dsel;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_TAKEN
    } t_cond;

    // one control word of the microprogram
    typedef struct packed {
        t_op               op;
        t_dsel             dsel;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic stall;
        logic taken;
    } t_flags;

    // leap rule over the reachable years: 2000 is leap, 2100 is not
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        return (year[1:0] == 2'b00) && (year != YEAR_W'(LEAP_SKIP));
    endfunction

    // month length, february stretched in a leap year
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/e2c_if.sv
// valid/ready channel interfaces for the input and result items
interface e2c_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_since_epoch;

    modport source (output valid, output seconds_since_epoch, input ready);
    modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface e2c_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [4:0] day_of_month;
    logic [3:0] month_of_year;

    modport source (output valid, output hour_of_day, output minute_of_hour,
                    output second_of_minute, output day_of_month, output month_of_year,
                    input ready);
    modport sink   (input valid, input hour_of_day, input minute_of_hour,
                    input second_of_minute, input day_of_month, input month_of_year,
                    output ready);
endinterface

// File: rtl/e2c_seq.sv
// microprogram sequencer: step counter, control store and jump logic
module e2c_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  e2c_pkg::t_flags i_flags,
    output e2c_pkg::t_uword o_uword
);
    import e2c_pkg::*;

    // program addresses
    localparam logic [STEP_W-1:0] ST_LOAD      = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_QUO_DAY   = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_TAKE_DAYS = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_QUO_HOUR  = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_TAKE_HOUR = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_QUO_MIN   = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_TAKE_MIN  = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_YEAR      = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_MONTH     = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_EMIT      = STEP_W'(9);

    // control store
    function automatic t_uword rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            ST_LOAD:      w = '{OP_LOAD,      DSEL_DAY,  COND_NEVER,    ST_LOAD};
            ST_QUO_DAY:   w = '{OP_QUO,       DSEL_DAY,  COND_NEVER,    ST_LOAD};
            ST_TAKE_DAYS: w = '{OP_TAKE_DAYS, DSEL_DAY,  COND_NEVER,    ST_LOAD};
            ST_QUO_HOUR:  w = '{OP_QUO,       DSEL_HOUR, COND_NEVER,    ST_LOAD};
            ST_TAKE_HOUR: w = '{OP_TAKE_HOUR, DSEL_HOUR, COND_NEVER,    ST_LOAD};
            ST_QUO_MIN:   w = '{OP_QUO,       DSEL_MIN,  COND_NEVER,    ST_LOAD};
            ST_TAKE_MIN:  w = '{OP_TAKE_MIN,  DSEL_MIN,  COND_NEVER,    ST_LOAD};
            ST_YEAR:      w = '{OP_YEAR,      DSEL_DAY,  COND_TAKEN,    ST_YEAR};
            ST_MONTH:     w = '{OP_MONTH,     DSEL_DAY,  COND_TAKEN,    ST_MONTH};
            ST_EMIT:      w = '{OP_EMIT,      DSEL_DAY,  COND_ALWAYS,   ST_LOAD};
            default:      w = '{OP_EMIT,      DSEL_DAY,  COND_ALWAYS,   ST_LOAD};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              w_jump;

    assign o_uword = rom(r_step);

    // jump condition
    always_comb begin
        case (o_uword.cond)
            COND_NEVER:    w_jump = 1'b0;
            COND_ALWAYS:   w_jump = 1'b1;
            COND_TAKEN:    w_jump = i_flags.taken;
            default:       w_jump = 1'b0;
        endcase
    end

    // next step: hold on stall, else jump or fall through
    always_comb begin
        if (i_flags.stall) begin
            n_step = r_step;
        end else if (w_jump) begin
            n_step = o_uword.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: rtl/epoch_seconds_to_calendar.sv
// top level: epoch seconds to time of day, day of month and month
//
// Usage: one input channel carries a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00 UTC; one output channel returns hour, minute, second,
// day of month and month for each input, in order, one result per input.
// Both channels use valid/ready; a transfer happens when both are high.
// A microprogram steps a small datapath: the count is divided by 86400,
// 3600 and 60 by reciprocal multiplication (a quotient step and a remainder
// step each), then whole years and months are walked off (one per cycle).
// The year walk grows with the whole years since 1970 (0 to 136) and
// the month walk with the month index (0 to 11).
// A new input is taken only when the sequencer is back at its load step,
// so each item is finished before the next is taken; the result sits in
// an output register, so the next input can start while it waits. If the
// receiver stalls, the finished result holds in the output register and
// the following result waits at its last step.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to the load step; the datapath registers are not reset.
module epoch_seconds_to_calendar (
    input  logic         i_clk,
    input  logic         i_rst_n,
    e2c_in_if.sink       i_in,
    e2c_out_if.source    o_out
);
    import e2c_pkg::*;

    t_uword w_uw;
    t_flags w_flags;

    // datapath registers
    logic [SECS_W-1:0]  r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [QUO_W-1:0]   r_days;
    logic [YEAR_W-1:0]  r_year;
    logic [3:0]         r_mon;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;

    // output register
    logic               r_out_valid;
    logic [4:0]         r_out_hour;
    logic [5:0]         r_out_min;
    logic [5:0]         r_out_sec;
    logic [4:0]         r_out_day;
    logic [3:0]         r_out_mon;

    logic [SECS_W-1:0]  w_div;
    logic [50:0]        w_day_prod;
    logic [25:0]        w_hour_prod;
    logic [19:0]        w_min_prod;
    logic [QUO_W-1:0]   w_quo;
    logic [SECS_W-1:0]  w_back;
    logic [SECS_W-1:0]  w_rem_next;
    logic               w_leap;
    logic [8:0]         w_ylen;
    logic [4:0]         w_mlen;
    logic               w_year_take;
    logic               w_mon_take;
    logic               w_out_free;

    e2c_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uw)
    );

    // divisor for the remainder step
    always_comb begin
        case (w_uw.dsel)
            DSEL_DAY:  w_div = SECS_W'(SECS_PER_DAY);
            DSEL_HOUR: w_div = SECS_W'(SECS_PER_HOUR);
            DSEL_MIN:  w_div = SECS_W'(SECS_PER_MIN);
            default:   w_div = SECS_W'(SECS_PER_DAY);
        endcase
    end

    // quotients by reciprocal multiplication, exact over each input range
    assign w_day_prod  = 51'(r_rem[31:7]) * 51'(DAY_RECIP);
    assign w_hour_prod = 26'(r_rem[16:4]) * 26'(HOUR_RECIP);
    assign w_min_prod  = 20'(r_rem[11:2]) * 20'(MIN_RECIP);

    always_comb begin
        case (w_uw.dsel)
            DSEL_DAY:  w_quo = w_day_prod[50:35];
            DSEL_HOUR: w_quo = QUO_W'(w_hour_prod[25:21]);
            DSEL_MIN:  w_quo = QUO_W'(w_min_prod[19:14]);
            default:   w_quo = w_day_prod[50:35];
        endcase
    end

    // remainder after the registered quotient
    assign w_back     = SECS_W'(r_quo) * w_div;
    assign w_rem_next = r_rem - w_back;

    // year and month lengths
    assign w_leap      = is_leap(r_year);
    assign w_ylen      = w_leap ? 9'd366 : 9'd365;
    assign w_mlen      = month_len(r_mon, w_leap);
    assign w_year_take = (r_days >= QUO_W'(w_ylen));
    assign w_mon_take  = (r_mon != LAST_MON) && (r_days >= QUO_W'(w_mlen));

    assign w_out_free = !r_out_valid || o_out.ready;

    // status for the sequencer
    always_comb begin
        w_flags.taken    = (w_uw.op == OP_YEAR) ? w_year_take : w_mon_take;
        w_flags.stall    = ((w_uw.op == OP_LOAD) && !i_in.valid)
                        || ((w_uw.op == OP_EMIT) && !w_out_free);
    end

    assign i_in.ready = (w_uw.op == OP_LOAD) && i_rst_n;

    // datapath, one operation per control word
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            OP_LOAD: begin
                r_rem   <= i_in.seconds_since_epoch;
            end
            OP_QUO: begin
                r_quo   <= w_quo;
            end
            OP_TAKE_DAYS: begin
                r_rem   <= w_rem_next;
                r_days  <= r_quo;
            end
            OP_TAKE_HOUR: begin
                r_rem   <= w_rem_next;
                r_hour  <= r_quo[4:0];
            end
            OP_TAKE_MIN: begin
                r_min  <= r_quo[5:0];
                r_sec  <= w_rem_next[5:0];
                r_year <= YEAR_W'(FIRST_YEAR);
                r_mon  <= '0;
            end
            OP_YEAR: begin
                if (w_year_take) begin
                    r_days <= r_days - QUO_W'(w_ylen);
                    r_year <= r_year + YEAR_W'(1);
                end
            end
            OP_MONTH: begin
                if (w_mon_take) begin
                    r_days <= r_days - QUO_W'(w_mlen);
                    r_mon  <= r_mon + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((w_uw.op == OP_EMIT) && w_out_free) begin
            r_out_hour <= r_hour;
            r_out_min  <= r_min;
            r_out_sec  <= r_sec;
            r_out_day  <= r_days[4:0] + 5'd1;
            r_out_mon  <= r_mon + 4'd1;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_uw.op == OP_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.hour_of_day      = r_out_hour;
    assign o_out.minute_of_hour   = r_out_min;
    assign o_out.second_of_minute = r_out_sec;
    assign o_out.day_of_month     = r_out_day;
    assign o_out.month_of_year    = r_out_mon;

endmodule

// File: rtl/e2c_chk.sv
// port-level checks for the epoch seconds to calendar block, with its bind
module e2c_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_hour,
    input logic [5:0] i_min,
    input logic [5:0] i_sec,
    input logic [4:0] i_day,
    input logic [3:0] i_mon
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hour) && $stable(i_min) && $stable(i_sec)
            && $stable(i_day) && $stable(i_mon))
        else $error("result changed while stalled");

    // the sequencer is busy right after it takes an input
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on two cycles in a row");

    // every field of a shown result is a real calendar value
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hour < 5'd24) && (i_min < 6'd60) && (i_sec < 6'd60)
            && (i_day != 5'd0) && (i_mon != 4'd0) && (i_mon < 4'd13))
        else $error("result field out of range");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 && $past(i_rst_n, 2) == 1'b0 |-> !i_out_valid)
        else $error("result shown after reset");

endmodule

bind epoch_seconds_to_calendar e2c_chk u_e2c_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hour      (o_out.hour_of_day),
    .i_min       (o_out.minute_of_hour),
    .i_sec       (o_out.second_of_minute),
    .i_day       (o_out.day_of_month),
    .i_mon       (o_out.month_of_year)
);
